@@ design/rdfc_pkg.sv @@
// Shared types, register indexes and constants of the remote desktop flow classifier.
package rdfc_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_BASE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_PORT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_STAGE = 3'd6;

  localparam logic [7:0]  RST_PACKET_LIMIT  = 8'd20;
  localparam logic [31:0] RST_RANGE_LOW     = 32'd1607673283;
  localparam logic [31:0] RST_RANGE_HIGH    = 32'd1607673291;
  localparam logic [31:0] RST_SUBNET_BASE   = 32'hB24D7800;
  localparam logic [31:0] RST_SUBNET_MASK   = 32'hFFFFFF80;
  localparam logic [15:0] RST_SERVICE_PORT  = 16'd5938;
  localparam logic [7:0]  RST_CONFIRM_STAGE = 8'd4;

  localparam logic [1:0] MODE_TCP = 2'd1;
  localparam logic [1:0] MODE_UDP = 2'd2;

  localparam logic [1:0] VERDICT_NONE     = 2'd0;
  localparam logic [1:0] VERDICT_DETECTED = 2'd1;
  localparam logic [1:0] VERDICT_GIVE_UP  = 2'd2;

  localparam logic [15:0] HTTP_MARK_WORD  = 16'h1724;
  localparam logic [16:0] HTTP_WORD_SPAN  = 17'd5;
  localparam logic [7:0]  MARK_HI         = 8'h17;
  localparam logic [7:0]  MARK_LO         = 8'h24;
  localparam logic [7:0]  CONT_HI         = 8'h11;
  localparam logic [7:0]  CONT_LO         = 8'h30;
  localparam logic [15:0] UDP_MIN_LEN     = 16'd13;
  localparam logic [15:0] TCP_MIN_LEN     = 16'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  packet_count;
    logic        http_body_ready;
    logic [15:0] empty_line_offset;
    logic [15:0] after_empty_line_word;
    logic        is_ipv4;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] payload_len;
    logic [31:0] probe_bytes;
  } in_item_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [7:0] stage_now;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  packet_limit;
    logic [31:0] range_low;
    logic [31:0] range_high;
    logic [31:0] subnet_base;
    logic [31:0] subnet_mask;
    logic [15:0] service_port;
    logic [7:0]  confirm_stage;
  } cfg_t;

endpackage

@@ design/rdfc_cfg.sv @@
// Configuration register file of the classifier.
module rdfc_cfg
  import rdfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  assign cfg_ready = 1'b1;
  assign wr_en = cfg_valid && cfg_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_index)
        CFG_PACKET_LIMIT:  cfg_nxt.packet_limit  = cfg_data[7:0];
        CFG_RANGE_LOW:     cfg_nxt.range_low     = cfg_data;
        CFG_RANGE_HIGH:    cfg_nxt.range_high    = cfg_data;
        CFG_SUBNET_BASE:   cfg_nxt.subnet_base   = cfg_data;
        CFG_SUBNET_MASK:   cfg_nxt.subnet_mask   = cfg_data;
        CFG_SERVICE_PORT:  cfg_nxt.service_port  = cfg_data[15:0];
        CFG_CONFIRM_STAGE: cfg_nxt.confirm_stage = cfg_data[7:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.packet_limit  <= RST_PACKET_LIMIT;
      cfg_r.range_low     <= RST_RANGE_LOW;
      cfg_r.range_high    <= RST_RANGE_HIGH;
      cfg_r.subnet_base   <= RST_SUBNET_BASE;
      cfg_r.subnet_mask   <= RST_SUBNET_MASK;
      cfg_r.service_port  <= RST_SERVICE_PORT;
      cfg_r.confirm_stage <= RST_CONFIRM_STAGE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ design/rdfc_decide.sv @@
// Per-item decision logic: limit, HTTP marker, address match and stage markers.
module rdfc_decide
  import rdfc_pkg::*;
(
  input  in_item_t  item,
  input  cfg_t      cfg,
  input  logic [7:0] stage,
  output logic [7:0] stage_nxt,
  output out_item_t  res
);

  function automatic logic addr_hit(input logic [31:0] a, input cfg_t c);
    addr_hit = (a >= c.range_low && a <= c.range_high) ||
               ((a & c.subnet_mask) == c.subnet_base);
  endfunction

  logic [7:0] b0, b1, b11, b12;
  logic [7:0] stage_inc;
  logic       port_hit;
  logic       http_fit;
  logic       inc_hit;
  logic [1:0] verdict;

  assign b0  = item.probe_bytes[31:24];
  assign b1  = item.probe_bytes[23:16];
  assign b11 = item.probe_bytes[15:8];
  assign b12 = item.probe_bytes[7:0];
  assign stage_inc = stage + 8'd1;
  assign inc_hit = (stage_inc == cfg.confirm_stage);
  assign port_hit = (item.src_port == cfg.service_port) ||
                    (item.dst_port == cfg.service_port);
  assign http_fit = ({1'b0, item.empty_line_offset} + HTTP_WORD_SPAN) <=
                    {1'b0, item.payload_len};

  always_comb begin
    stage_nxt = stage;
    verdict   = VERDICT_NONE;
    priority if (item.packet_count > cfg.packet_limit) begin
      verdict = VERDICT_GIVE_UP;
    end else if (item.http_body_ready && http_fit &&
                 item.after_empty_line_word == HTTP_MARK_WORD) begin
      verdict = VERDICT_DETECTED;
    end else if (item.is_ipv4 &&
                 (addr_hit(item.src_addr, cfg) || addr_hit(item.dst_addr, cfg))) begin
      verdict = VERDICT_DETECTED;
    end else if (item.payload_len == '0) begin
      verdict = VERDICT_NONE;
    end else if (item.mode == MODE_UDP) begin
      if (item.payload_len > UDP_MIN_LEN && b0 == 8'h00 &&
          b11 == MARK_HI && b12 == MARK_LO) begin
        stage_nxt = stage_inc;
        if (inc_hit || port_hit) verdict = VERDICT_DETECTED;
      end
    end else if (item.mode == MODE_TCP) begin
      if (item.payload_len > TCP_MIN_LEN) begin
        priority if (b0 == MARK_HI && b1 == MARK_LO) begin
          stage_nxt = stage_inc;
          if (inc_hit || port_hit) verdict = VERDICT_DETECTED;
        end else if (stage != '0 && b0 == CONT_HI && b1 == CONT_LO) begin
          stage_nxt = stage_inc;
          if (inc_hit) verdict = VERDICT_DETECTED;
        end else begin
          stage_nxt = stage;
        end
      end
    end else begin
      verdict = VERDICT_NONE;
    end
  end

  assign res.verdict   = verdict;
  assign res.stage_now = stage_nxt;

endmodule

@@ design/remote_desktop_flow_classifier_top.sv @@
// Top level of the remote desktop flow classifier: input register, decision, result register.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   in_item  (in_item_t)
//   out_     output     out_valid / out_stall out_item (out_item_t)
//   cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; each result is registered before out_.
// The stage counter is the only loop: it updates in the cycle an item moves to the
// result register. Reset clears the stage counter and loads register defaults.
// A stalled result holds the result register; the input register keeps taking
// items until it too is full.
module remote_desktop_flow_classifier_top
  import rdfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  in_item_t  in_item_r;
  logic      in_valid_r, in_valid_nxt;
  out_item_t out_item_r, res;
  logic      out_valid_r, out_valid_nxt;
  logic [7:0] stage_r, stage_nxt, stage_calc;
  logic      out_free, adv, take;

  rdfc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rdfc_decide u_decide (
    .item      (in_item_r),
    .cfg       (cfg),
    .stage     (stage_r),
    .stage_nxt (stage_calc),
    .res       (res)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign take     = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt  = take ? 1'b1 : (adv ? 1'b0 : in_valid_r);
    out_valid_nxt = adv ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
    stage_nxt     = adv ? stage_calc : stage_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      stage_r     <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      stage_r     <= stage_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_item_r <= in_item;
    end
    if (adv) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_stage_reset: assert property (@(posedge clk) !rst_n |=> stage_r == '0)
    else $error("stage counter not cleared by reset");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(stage_r))
    else $error("stage counter moved without an item advancing");

  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r && out_item_r.stage_now == stage_r)
    else $error("advanced item lost or stage mismatch in result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !adv |=> in_valid_r && $stable(in_item_r))
    else $error("pending item overwritten");

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the remote desktop flow classifier top level.
`timescale 1ns / 1ps

module tb;
  import rdfc_pkg::*;

  localparam logic [1:0] MODE_OTHER = 2'd0;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int NUM_PHASES = 5;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit        row_typed = 1'b0;
  out_item_t row_result = '0;

  cfg_t       cfg_shadow;
  logic [7:0] stage_shadow;
  cfg_t       plan;
  out_item_t  expected_verdicts[$];
  row_t       directed_rows[$];
  int         mismatches = 0;
  int         idle_cycles = 0;
  int         gap_pct = 0;
  int         stall_pct = 0;

  remote_desktop_flow_classifier_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic bit server_addr(input logic [31:0] a);
    if (a >= cfg_shadow.range_low && a <= cfg_shadow.range_high) return 1'b1;
    return (a & cfg_shadow.subnet_mask) == cfg_shadow.subnet_base;
  endfunction

  function automatic out_item_t classify_packet(input in_item_t p);
    out_item_t   r;
    logic [7:0]  b0, b1, b11, b12;
    logic [16:0] http_end;
    bit          port_hit;
    b0 = p.probe_bytes[31:24];
    b1 = p.probe_bytes[23:16];
    b11 = p.probe_bytes[15:8];
    b12 = p.probe_bytes[7:0];
    port_hit = (p.src_port == cfg_shadow.service_port) ||
               (p.dst_port == cfg_shadow.service_port);
    http_end = {1'b0, p.empty_line_offset} + HTTP_WORD_SPAN;
    r.verdict = VERDICT_NONE;
    if (p.packet_count > cfg_shadow.packet_limit) begin
      r.verdict = VERDICT_GIVE_UP;
    end else if (p.http_body_ready && http_end <= {1'b0, p.payload_len} &&
                 p.after_empty_line_word == HTTP_MARK_WORD) begin
      r.verdict = VERDICT_DETECTED;
    end else if (p.is_ipv4 && (server_addr(p.src_addr) || server_addr(p.dst_addr))) begin
      r.verdict = VERDICT_DETECTED;
    end else if (p.payload_len == 16'd0) begin
      r.verdict = VERDICT_NONE;
    end else if (p.mode == MODE_UDP) begin
      if (p.payload_len > UDP_MIN_LEN && b0 == 8'h00 && b11 == MARK_HI && b12 == MARK_LO) begin
        stage_shadow = stage_shadow + 8'd1;
        if (stage_shadow == cfg_shadow.confirm_stage || port_hit) r.verdict = VERDICT_DETECTED;
      end
    end else if (p.mode == MODE_TCP && p.payload_len > TCP_MIN_LEN) begin
      if (b0 == MARK_HI && b1 == MARK_LO) begin
        stage_shadow = stage_shadow + 8'd1;
        if (stage_shadow == cfg_shadow.confirm_stage || port_hit) r.verdict = VERDICT_DETECTED;
      end else if (stage_shadow != 8'd0 && b0 == CONT_HI && b1 == CONT_LO) begin
        stage_shadow = stage_shadow + 8'd1;
        if (stage_shadow == cfg_shadow.confirm_stage) r.verdict = VERDICT_DETECTED;
      end
    end
    r.stage_now = stage_shadow;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    out_item_t want;
    bit        moved;
    if (!rst_n) begin
      cfg_shadow = '{packet_limit: RST_PACKET_LIMIT, range_low: RST_RANGE_LOW,
                     range_high: RST_RANGE_HIGH, subnet_base: RST_SUBNET_BASE,
                     subnet_mask: RST_SUBNET_MASK, service_port: RST_SERVICE_PORT,
                     confirm_stage: RST_CONFIRM_STAGE};
      stage_shadow = 8'd0;
      idle_cycles = 0;
    end else begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          CFG_PACKET_LIMIT:  cfg_shadow.packet_limit = cfg_data[7:0];
          CFG_RANGE_LOW:     cfg_shadow.range_low = cfg_data;
          CFG_RANGE_HIGH:    cfg_shadow.range_high = cfg_data;
          CFG_SUBNET_BASE:   cfg_shadow.subnet_base = cfg_data;
          CFG_SUBNET_MASK:   cfg_shadow.subnet_mask = cfg_data;
          CFG_SERVICE_PORT:  cfg_shadow.service_port = cfg_data[15:0];
          CFG_CONFIRM_STAGE: cfg_shadow.confirm_stage = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        want = classify_packet(in_item);
        expected_verdicts.push_back(row_typed ? row_result : want);
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_verdicts.size() == 0) begin
          $display("%0t unexpected item: expected none, got verdict %0d stage %0d",
                   $time, out_item.verdict, out_item.stage_now);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_item.verdict !== want.verdict) begin
            $display("%0t verdict mismatch: expected %0d, got %0d",
                     $time, want.verdict, out_item.verdict);
            mismatches++;
          end
          if (out_item.stage_now !== want.stage_now) begin
            $display("%0t stage mismatch: expected %0d, got %0d",
                     $time, want.stage_now, out_item.stage_now);
            mismatches++;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic push_item(input in_item_t it, input bit typed, input out_item_t typed_res);
    in_valid <= 1'b1;
    in_item <= it;
    row_typed <= typed;
    row_result <= typed_res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(input cfg_t s);
    logic [31:0] vals [CFG_PACKET_LIMIT:CFG_CONFIRM_STAGE];
    vals[CFG_PACKET_LIMIT] = {24'd0, s.packet_limit};
    vals[CFG_RANGE_LOW] = s.range_low;
    vals[CFG_RANGE_HIGH] = s.range_high;
    vals[CFG_SUBNET_BASE] = s.subnet_base;
    vals[CFG_SUBNET_MASK] = s.subnet_mask;
    vals[CFG_SERVICE_PORT] = {16'd0, s.service_port};
    vals[CFG_CONFIRM_STAGE] = {24'd0, s.confirm_stage};
    for (int i = CFG_PACKET_LIMIT; i <= CFG_CONFIRM_STAGE; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    plan = s;
  endtask

  task automatic add_row(input in_item_t it, input bit typed, input logic [1:0] verdict);
    row_t r;
    r.item = it;
    r.typed = typed;
    r.result.verdict = verdict;
    r.result.stage_now = 8'd0;
    directed_rows.push_back(r);
  endtask

  function automatic logic [31:0] server_address();
    if ($urandom_range(1) == 0 && plan.range_low <= plan.range_high)
      return $urandom_range(plan.range_high, plan.range_low);
    return (plan.subnet_base & plan.subnet_mask) | ($urandom & ~plan.subnet_mask);
  endfunction

  function automatic in_item_t rand_packet();
    in_item_t     p;
    logic [191:0] noise;
    int           pick;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    p = noise[$bits(in_item_t)-1:0];
    case ($urandom_range(9))
      0:          p.mode = MODE_OTHER;
      1:          p.mode = MODE_SPARE;
      2, 3, 4, 5: p.mode = MODE_TCP;
      default:    p.mode = MODE_UDP;
    endcase
    if ($urandom_range(99) < 85) p.packet_count = 8'($urandom_range(plan.packet_limit, 0));
    p.http_body_ready = ($urandom_range(9) == 0);
    if (p.http_body_ready && $urandom_range(9) < 7)
      p.empty_line_offset = 16'($urandom_range(40));
    if ($urandom_range(1) == 0) p.after_empty_line_word = HTTP_MARK_WORD;
    p.is_ipv4 = ($urandom_range(9) < 6);
    if ($urandom_range(9) == 0) p.src_addr = server_address();
    if ($urandom_range(9) == 0) p.dst_addr = server_address();
    case ($urandom_range(9))
      0: p.src_port = plan.service_port;
      1: p.dst_port = plan.service_port;
      default: ;
    endcase
    pick = $urandom_range(19);
    if (pick == 0) p.payload_len = 16'd0;
    else if (pick == 2) p.payload_len = TCP_MIN_LEN + 16'($urandom_range(1));
    else if (pick == 3) p.payload_len = UDP_MIN_LEN + 16'($urandom_range(1));
    else if (pick != 1) p.payload_len = 16'($urandom_range(64, 1));
    pick = $urandom_range(99);
    if (p.mode == MODE_UDP) begin
      if (pick < 55) begin
        p.probe_bytes[31:24] = 8'h00;
        p.probe_bytes[15:0] = {MARK_HI, MARK_LO};
      end
    end else if (pick < 45) begin
      p.probe_bytes[31:16] = {MARK_HI, MARK_LO};
    end else if (pick < 70) begin
      p.probe_bytes[31:16] = {CONT_HI, CONT_LO};
    end
    return p;
  endfunction

  initial begin : stimulus
    in_item_t quiet, it;
    cfg_t     phase_cfg [NUM_PHASES];
    int       phase_gap [NUM_PHASES] = '{0, 59, 0, 26, 0};
    int       phase_stall [NUM_PHASES] = '{0, 0, 59, 26, 0};

    phase_cfg[0] = '{packet_limit: RST_PACKET_LIMIT, range_low: RST_RANGE_LOW,
                     range_high: RST_RANGE_HIGH, subnet_base: RST_SUBNET_BASE,
                     subnet_mask: RST_SUBNET_MASK, service_port: RST_SERVICE_PORT,
                     confirm_stage: RST_CONFIRM_STAGE};
    phase_cfg[1] = '{8'd255, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     16'd0, 8'd1};
    phase_cfg[2] = '{8'd0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 16'hFFFF, 8'd255};
    phase_cfg[3] = '{8'd128, 32'h0A00_0000, 32'h0A00_00FF, 32'hC0A8_0000, 32'hFFFF_0000,
                     16'd3389, 8'd7};
    phase_cfg[4] = '{8'd64, 32'h7F00_0001, 32'h7F00_0001, 32'h8000_0000, 32'h8000_0000,
                     RST_SERVICE_PORT, 8'd2};
    plan = phase_cfg[0];

    quiet = '0;
    quiet.packet_count = 8'd1;
    it = quiet; it.packet_count = 8'd255;                  add_row(it, 1'b1, VERDICT_GIVE_UP);
    it = quiet; it.packet_count = RST_PACKET_LIMIT + 8'd1; add_row(it, 1'b1, VERDICT_GIVE_UP);
    it = quiet; it.packet_count = RST_PACKET_LIMIT;        add_row(it, 1'b1, VERDICT_NONE);
    it = quiet; it.http_body_ready = 1'b1; it.payload_len = 16'd5;
    it.after_empty_line_word = HTTP_MARK_WORD;              add_row(it, 1'b1, VERDICT_DETECTED);
    it.empty_line_offset = 16'd1; it.mode = MODE_TCP;      add_row(it, 1'b1, VERDICT_NONE);
    it = quiet; it.http_body_ready = 1'b1; it.empty_line_offset = 16'hFFFF;
    it.payload_len = 16'hFFFF; it.after_empty_line_word = HTTP_MARK_WORD;
                                                            add_row(it, 1'b1, VERDICT_NONE);
    it = quiet; it.is_ipv4 = 1'b1; it.src_addr = RST_RANGE_LOW;
                                                            add_row(it, 1'b1, VERDICT_DETECTED);
    it = quiet; it.is_ipv4 = 1'b1; it.dst_addr = RST_RANGE_HIGH;
                                                            add_row(it, 1'b1, VERDICT_DETECTED);
    it = quiet; it.is_ipv4 = 1'b1; it.src_addr = RST_RANGE_HIGH + 32'd1;
    it.dst_addr = RST_RANGE_LOW - 32'd1;                    add_row(it, 1'b1, VERDICT_NONE);
    it = quiet; it.is_ipv4 = 1'b1; it.dst_addr = RST_SUBNET_BASE | ~RST_SUBNET_MASK;
                                                            add_row(it, 1'b1, VERDICT_DETECTED);
    it = quiet; it.src_addr = RST_RANGE_LOW;               add_row(it, 1'b1, VERDICT_NONE);
    it = quiet; it.mode = MODE_SPARE; it.payload_len = 16'd100;
    it.probe_bytes = {MARK_HI, MARK_LO, 16'h0};             add_row(it, 1'b1, VERDICT_NONE);
    it = quiet; it.mode = MODE_TCP; it.payload_len = 16'd3;
    it.probe_bytes = {CONT_HI, CONT_LO, 16'h0};             add_row(it, 1'b1, VERDICT_NONE);
    it = quiet; it.mode = MODE_TCP; it.payload_len = TCP_MIN_LEN;
    it.probe_bytes = {MARK_HI, MARK_LO, 16'h0};             add_row(it, 1'b1, VERDICT_NONE);
    it.payload_len = 16'd0;                                 add_row(it, 1'b1, VERDICT_NONE);
    it.payload_len = 16'd3;                                 add_row(it, 1'b0, VERDICT_NONE);
    it.probe_bytes = {CONT_HI, CONT_LO, 16'h0};             add_row(it, 1'b0, VERDICT_NONE);
    it = quiet; it.mode = MODE_UDP; it.payload_len = UDP_MIN_LEN;
    it.probe_bytes = {16'h0000, MARK_HI, MARK_LO};          add_row(it, 1'b0, VERDICT_NONE);
    it.payload_len = UDP_MIN_LEN + 16'd1;
    it.probe_bytes = {16'h00FF, MARK_HI, MARK_LO};          add_row(it, 1'b0, VERDICT_NONE);
    it = quiet; it.mode = MODE_TCP; it.payload_len = 16'hFFFF; it.dst_port = RST_SERVICE_PORT;
    it.probe_bytes = {CONT_HI, CONT_LO, 16'hFFFF};          add_row(it, 1'b0, VERDICT_NONE);
    it = quiet; it.mode = MODE_UDP; it.payload_len = UDP_MIN_LEN + 16'd1;
    it.src_port = RST_SERVICE_PORT; it.probe_bytes = {16'h0000, MARK_HI, MARK_LO};
                                                            add_row(it, 1'b0, VERDICT_NONE);
    it = quiet; it.mode = MODE_TCP; it.payload_len = 16'd3; it.src_port = RST_SERVICE_PORT;
    it.probe_bytes = {CONT_HI, CONT_LO, 16'h0};             add_row(it, 1'b0, VERDICT_NONE);
    it = '1;                                                add_row(it, 1'b0, VERDICT_NONE);
    it = '0;                                                add_row(it, 1'b0, VERDICT_NONE);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      push_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
    wait_for_results();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      apply_settings(phase_cfg[ph]);
      gap_pct = phase_gap[ph];
      stall_pct = phase_stall[ph];
      repeat (ITEMS_PER_PHASE) begin
        while ($urandom_range(99) < gap_pct) begin
          in_valid <= 1'b0;
          @(posedge clk);
        end
        push_item(rand_packet(), 1'b0, '0);
      end
      wait_for_results();
    end

    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
design/rdfc_pkg.sv
design/rdfc_cfg.sv
design/rdfc_decide.sv
design/remote_desktop_flow_classifier_top.sv
sim/tb.sv
